[sv/gcd_pkg.sv]
// Package for the GCD/LCM unit: microcode word layout, opcodes, jump conditions
// and the control store contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

	localparam int OPERAND_BITS_DEF = 16;
	localparam int FIELD_BITS       = 16;
	localparam int MULTIPLE_BITS    = 32;
	localparam int PC_BITS          = 4;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_HALVE_XY,
		OP_HALVE_X,
		OP_HALVE_Y,
		OP_SUB,
		OP_GCD,
		OP_DIV,
		OP_MULSET,
		OP_MUL,
		OP_DONE,
		OP_ERR
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_ZERO,
		COND_BOTH_EVEN,
		COND_X_EVEN,
		COND_Y_EVEN,
		COND_DIFF_NZ,
		COND_MORE
	} cond_t;

	typedef struct packed {
		op_t                  op;
		cond_t                cond;
		logic [PC_BITS-1:0]   target;
	} ucode_t;

	localparam logic [PC_BITS-1:0] STEP_CHECK  = 4'd0;
	localparam logic [PC_BITS-1:0] STEP_STRIP2 = 4'd1;
	localparam logic [PC_BITS-1:0] STEP_STRIPX = 4'd2;
	localparam logic [PC_BITS-1:0] STEP_STRIPY = 4'd3;
	localparam logic [PC_BITS-1:0] STEP_SUB    = 4'd4;
	localparam logic [PC_BITS-1:0] STEP_GCD    = 4'd5;
	localparam logic [PC_BITS-1:0] STEP_DIV    = 4'd6;
	localparam logic [PC_BITS-1:0] STEP_MULSET = 4'd7;
	localparam logic [PC_BITS-1:0] STEP_MUL    = 4'd8;
	localparam logic [PC_BITS-1:0] STEP_DONE   = 4'd9;
	localparam logic [PC_BITS-1:0] STEP_ERR    = 4'd10;

	// Control store. A step jumps to target when its condition holds, else falls through.
	function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
		ucode_t w;
		case (pc)
			STEP_CHECK:  w = '{OP_NOP,      COND_ZERO,      STEP_ERR};
			STEP_STRIP2: w = '{OP_HALVE_XY, COND_BOTH_EVEN, STEP_STRIP2};
			STEP_STRIPX: w = '{OP_HALVE_X,  COND_X_EVEN,    STEP_STRIPX};
			STEP_STRIPY: w = '{OP_HALVE_Y,  COND_Y_EVEN,    STEP_STRIPY};
			STEP_SUB:    w = '{OP_SUB,      COND_DIFF_NZ,   STEP_STRIPY};
			STEP_GCD:    w = '{OP_GCD,      COND_NEVER,     STEP_CHECK};
			STEP_DIV:    w = '{OP_DIV,      COND_MORE,      STEP_DIV};
			STEP_MULSET: w = '{OP_MULSET,   COND_NEVER,     STEP_CHECK};
			STEP_MUL:    w = '{OP_MUL,      COND_MORE,      STEP_MUL};
			STEP_DONE:   w = '{OP_DONE,     COND_NEVER,     STEP_CHECK};
			STEP_ERR:    w = '{OP_ERR,      COND_NEVER,     STEP_CHECK};
			default:     w = '{OP_ERR,      COND_NEVER,     STEP_CHECK};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[sv/gcd_lcm_unit.sv]
// GCD / LCM unit: a microcoded sequencer over a small shift/subtract datapath.
// Depends on gcd_pkg (control store, opcodes, conditions).
//
// A request is taken when start is high and busy is low; operand bits above
// W = min(OPERAND_BITS, 16) are dropped. The divisor comes from binary GCD
// (halve / subtract steps), the multiple from (a / gcd) * b using a W-step
// restoring divider and a W-step shift-add multiplier, all run by one step
// of the control store per clock. A request with a zero operand returns
// zeros with bad_operand set. Otherwise the number of binary GCD steps
// depends on the operands. busy stays high until the result is issued.
// The result is shown for exactly one cycle with done high; the receiver
// cannot stall it, so it must capture it in that cycle. A new request may
// be taken in the same cycle that done is high.
`timescale 1ns / 1ps
`default_nettype none

module gcd_lcm_unit #(
	parameter int OPERAND_BITS = gcd_pkg::OPERAND_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output      logic                             busy,
	input  wire logic [gcd_pkg::FIELD_BITS-1:0]    operand_a,
	input  wire logic [gcd_pkg::FIELD_BITS-1:0]    operand_b,
	output      logic                             done,
	output      logic [gcd_pkg::FIELD_BITS-1:0]    divisor,
	output      logic [gcd_pkg::MULTIPLE_BITS-1:0] multiple,
	output      logic                             bad_operand
);

	localparam int W  = (OPERAND_BITS < gcd_pkg::FIELD_BITS) ? OPERAND_BITS
	                                                          : gcd_pkg::FIELD_BITS;
	localparam int KW = $clog2(W + 1);
	localparam int CW = $clog2(W + 1);
	localparam logic [CW-1:0] CNT_LOAD = CW'(W);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	logic                          run_q;
	logic [gcd_pkg::PC_BITS-1:0]   pc_q;
	logic                          done_q;

	logic [W-1:0]   x_q, y_q, a_q, b_q, g_q, quo_q, rem_q;
	logic [KW-1:0]  k_q;
	logic [CW-1:0]  cnt_q;
	logic [2*W-1:0] prod_q;

	logic [gcd_pkg::FIELD_BITS-1:0]    divisor_q;
	logic [gcd_pkg::MULTIPLE_BITS-1:0] multiple_q;
	logic                              bad_q;

	gcd_pkg::ucode_t uw;
	logic            accept;
	logic            take;
	logic [W-1:0]    diff;
	logic            x_gt_y;
	logic [W:0]      rem_try;
	logic [W:0]      rem_sub;
	logic [W:0]      mul_sum;

	assign accept = start && !run_q;
	assign uw     = gcd_pkg::ucode_rom(pc_q);

	assign x_gt_y  = x_q > y_q;
	assign diff    = x_gt_y ? (x_q - y_q) : (y_q - x_q);
	assign rem_try = {rem_q, quo_q[W-1]};
	assign rem_sub = rem_try - {1'b0, g_q};
	assign mul_sum = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, b_q} : '0);

	always_comb begin
		case (uw.cond)
			gcd_pkg::COND_NEVER:     take = 1'b0;
			gcd_pkg::COND_ALWAYS:    take = 1'b1;
			gcd_pkg::COND_ZERO:      take = (x_q == '0) || (y_q == '0);
			gcd_pkg::COND_BOTH_EVEN: take = !x_q[0] && !y_q[0];
			gcd_pkg::COND_X_EVEN:    take = !x_q[0];
			gcd_pkg::COND_Y_EVEN:    take = !y_q[0];
			gcd_pkg::COND_DIFF_NZ:   take = x_q != y_q;
			gcd_pkg::COND_MORE:      take = cnt_q != CNT_ONE;
			default:                 take = 1'b0;
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			pc_q   <= gcd_pkg::STEP_CHECK;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (uw.op == gcd_pkg::OP_DONE || uw.op == gcd_pkg::OP_ERR);
			if (accept) begin
				run_q <= 1'b1;
				pc_q  <= gcd_pkg::STEP_CHECK;
			end else if (run_q) begin
				if (uw.op == gcd_pkg::OP_DONE || uw.op == gcd_pkg::OP_ERR) begin
					run_q <= 1'b0;
				end
				pc_q <= take ? uw.target : pc_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= operand_a[W-1:0];
			y_q <= operand_b[W-1:0];
			a_q <= operand_a[W-1:0];
			b_q <= operand_b[W-1:0];
			k_q <= '0;
		end else if (run_q) begin
			case (uw.op)
				gcd_pkg::OP_HALVE_XY: begin
					if (take) begin
						x_q <= x_q >> 1;
						y_q <= y_q >> 1;
						k_q <= k_q + 1'b1;
					end
				end
				gcd_pkg::OP_HALVE_X: begin
					if (take)
						x_q <= x_q >> 1;
				end
				gcd_pkg::OP_HALVE_Y: begin
					if (take)
						y_q <= y_q >> 1;
				end
				gcd_pkg::OP_SUB: begin
					// both odd here: keep the smaller, replace the other by the even difference
					x_q <= x_gt_y ? y_q : x_q;
					y_q <= diff;
				end
				gcd_pkg::OP_GCD: begin
					g_q   <= x_q << k_q;
					rem_q <= '0;
					quo_q <= a_q;
					cnt_q <= CNT_LOAD;
				end
				gcd_pkg::OP_DIV: begin
					if (!rem_sub[W]) begin
						rem_q <= rem_sub[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= rem_try[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
				end
				gcd_pkg::OP_MULSET: begin
					prod_q <= {{W{1'b0}}, quo_q};
					cnt_q  <= CNT_LOAD;
				end
				gcd_pkg::OP_MUL: begin
					prod_q <= {mul_sum, prod_q[W-1:1]};
					cnt_q  <= cnt_q - 1'b1;
				end
				gcd_pkg::OP_DONE: begin
					divisor_q  <= gcd_pkg::FIELD_BITS'(g_q);
					multiple_q <= gcd_pkg::MULTIPLE_BITS'(prod_q);
					bad_q      <= 1'b0;
				end
				gcd_pkg::OP_ERR: begin
					divisor_q  <= '0;
					multiple_q <= '0;
					bad_q      <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy        = run_q;
	assign done        = done_q;
	assign divisor     = divisor_q;
	assign multiple    = multiple_q;
	assign bad_operand = bad_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Testbench for gcd_lcm_unit: sends operand pairs over the start/busy request
// interface and checks each done strobe against a built-in Euclid predictor.
// Depends on gcd_pkg and gcd_lcm_unit.
`timescale 1ns / 1ps

module testbench;

	localparam int FB = gcd_pkg::FIELD_BITS;
	localparam int MB = gcd_pkg::MULTIPLE_BITS;

	typedef struct {
		logic [FB-1:0] divisor;
		logic [MB-1:0] multiple;
		logic          bad_operand;
	} gcd_lcm_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [FB-1:0] operand_a = '0;
	logic [FB-1:0] operand_b = '0;
	logic          busy;
	logic          done;
	logic [FB-1:0] divisor;
	logic [MB-1:0] multiple;
	logic          bad_operand;

	gcd_lcm_t pending_gcd_lcm[$];
	int       mismatch_count = 0;
	int       sender_idle_pct = 0;

	gcd_lcm_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.done        (done),
		.divisor     (divisor),
		.multiple    (multiple),
		.bad_operand (bad_operand)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	function automatic gcd_lcm_t gcd_lcm_of(input logic [FB-1:0] a, input logic [FB-1:0] b);
		logic [FB-1:0] x;
		logic [FB-1:0] y;
		logic [FB-1:0] r;
		gcd_lcm_t      res;
		res.divisor = '0;
		res.multiple = '0;
		res.bad_operand = 1'b1;
		if (a != 0 && b != 0) begin
			x = a;
			y = b;
			while (y != 0) begin
				r = x % y;
				x = y;
				y = r;
			end
			res.divisor = x;
			// (a / gcd) * b always fits 32 bits for 16-bit operands
			res.multiple = MB'(a / x) * MB'(b);
			res.bad_operand = 1'b0;
		end
		return res;
	endfunction

	// One request: wait for a free unit plus optional idle cycles, then hold
	// start until busy is low at an edge.
	task automatic send_request(input logic [FB-1:0] a, input logic [FB-1:0] b);
		while (busy || $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_gcd_lcm.push_back(gcd_lcm_of(a, b));
	endtask

	always @(posedge clk) begin
		gcd_lcm_t want;
		if (arst_n && done) begin
			if (pending_gcd_lcm.size() == 0) begin
				$error("result with no request outstanding: divisor %0d multiple %0d bad %0b",
					divisor, multiple, bad_operand);
				mismatch_count++;
			end else begin
				want = pending_gcd_lcm.pop_front();
				if (divisor !== want.divisor) begin
					$error("divisor: expected %0d, got %0d", want.divisor, divisor);
					mismatch_count++;
				end
				if (multiple !== want.multiple) begin
					$error("multiple: expected %0d, got %0d", want.multiple, multiple);
					mismatch_count++;
				end
				if (bad_operand !== want.bad_operand) begin
					$error("bad_operand: expected %0b, got %0b", want.bad_operand, bad_operand);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_zero_operand();
		send_request(16'h0000, 16'h0000);
		send_request(16'h0000, 16'h0001);
		send_request(16'h0001, 16'h0000);
		send_request(16'h0000, 16'hFFFF);
		send_request(16'hFFFF, 16'h0000);
	endtask

	task automatic test_field_extremes();
		send_request(16'h0001, 16'h0001);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'h0001, 16'hFFFF);
		send_request(16'hFFFF, 16'h0001);
		send_request(16'hFFFF, 16'hFFFE);
		send_request(16'd65521, 16'd65519);
		send_request(16'hAAAA, 16'h5555);
		send_request(16'd12, 16'd18);
	endtask

	// operands with factors of two exercise the halving steps of the binary gcd
	task automatic test_even_stripping();
		send_request(16'h8000, 16'h8000);
		send_request(16'h8000, 16'h0001);
		send_request(16'h8000, 16'hFFFF);
		send_request(16'h4000, 16'h0006);
		send_request(16'hFFF0, 16'h0F00);
		send_request(16'h0002, 16'h8000);
	endtask

	task automatic test_random_mix(input int count, input int idle_pct);
		int            kind;
		int            g;
		logic [FB-1:0] a;
		logic [FB-1:0] b;
		sender_idle_pct = idle_pct;
		repeat (count) begin
			kind = $urandom_range(99);
			if (kind < 4) begin
				a = $urandom_range(3) == 0 ? 16'h0000 : FB'($urandom());
				b = FB'($urandom());
				if ($urandom_range(1)) b = '0;
				else a = '0;
			end else if (kind < 40) begin
				// shared factor g, so the divisor is a multiple of g
				g = $urandom_range(1, 255);
				a = FB'(g * $urandom_range(1, 65535 / g));
				b = FB'(g * $urandom_range(1, 65535 / g));
			end else if (kind < 60) begin
				a = FB'($urandom_range(1, 64));
				b = FB'($urandom_range(1, 64));
			end else if (kind < 70) begin
				a = FB'($urandom()) << $urandom_range(0, 15);
				b = FB'($urandom()) << $urandom_range(0, 15);
			end else begin
				a = FB'($urandom());
				b = FB'($urandom());
			end
			send_request(a, b);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_operand();
		test_field_extremes();
		test_even_stripping();
		test_random_mix(360, 14);
		test_random_mix(360, 46);
		test_random_mix(360, 0);
		start <= 1'b0;
		while (pending_gcd_lcm.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
